// ----- rtl/drws_pkg.sv -----
// ---------------------------------------------------------------------------
// drws_pkg
// Shared constants and types for the read/write mode switch.
// ---------------------------------------------------------------------------
`default_nettype none
package drws_pkg;

  localparam int CHANNELS_DEF   = 2;
  localparam int COUNT_BITS_DEF = 7;

  localparam int THR_W      = 7;
  localparam int DELAY_W    = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_RD_COUNT_THR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WR_COUNT_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WR_SW_DELAY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PREFER_WR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WR_BUF_THR   = 3'd4;

  localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};

  typedef struct packed {
    logic [THR_W-1:0]   rd_count_threshold;
    logic [THR_W-1:0]   wr_count_threshold;
    logic [DELAY_W-1:0] write_switch_delay;
    logic               prefer_write;
    logic [THR_W-1:0]   wr_buffer_threshold;
  } cfg_t;

  typedef struct packed {
    logic rd_below;
    logic wr_below;
    logic rd_med;
    logic wr_med;
    logic rd_avail;
    logic wr_avail;
    logic rd_valid;
    logic wr_valid;
    logic buf_above;
  } lane_flags_t;

  typedef struct packed {
    logic exp_rd;
    logic exp_wr;
    logic flush_rd;
    logic flush_wr_opening;
    logic flush_wr_open;
    logic rd_crit;
    logic wr_crit;
  } urgency_t;

endpackage
`default_nettype wire

// ----- rtl/dram_read_write_mode_switch.sv -----
// ---------------------------------------------------------------------------
// dram_read_write_mode_switch
// Read/write turnaround policy: one decision per controller cycle snapshot.
// ---------------------------------------------------------------------------
//  channel   signals                              direction
//  cfg       cfg_valid/cfg_ready, index, data     in
//  in        in_valid/in_ready, flags and counts  in
//  out       out_valid/out_ready, mode and masks  out
//
//  One snapshot per cycle while in_ready is high; the result is registered
//  at the transfer. Mode and delay state update at the transfer. A skid
//  entry takes one transfer while the output is stalled; in_ready is low
//  while it is occupied. Synchronous reset gives read mode and the register
//  reset values; a config write applies to transfers from the cycle after
//  the write.
// ---------------------------------------------------------------------------
`default_nettype none
module dram_read_write_mode_switch #(
  parameter int CHANNELS   = drws_pkg::CHANNELS_DEF,
  parameter int COUNT_BITS = drws_pkg::COUNT_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [drws_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [drws_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [CHANNELS-1:0]               expired_rd_hit_opening,
  input  wire logic [CHANNELS-1:0]               expired_wr_hit_opening,
  input  wire logic [CHANNELS-1:0]               urgent_rd_hit_opening,
  input  wire logic [CHANNELS-1:0]               urgent_wr_hit_opening,
  input  wire logic [CHANNELS-1:0]               urgent_wr_hit_open,
  input  wire logic [CHANNELS-1:0]               rd_critical_hit_opening,
  input  wire logic [CHANNELS-1:0]               wr_critical_hit_open,
  input  wire logic [CHANNELS*COUNT_BITS-1:0]    rd_ready_counts,
  input  wire logic [CHANNELS*COUNT_BITS-1:0]    wr_ready_counts,
  input  wire logic [CHANNELS*COUNT_BITS-1:0]    rd_pending_counts,
  input  wire logic [CHANNELS*COUNT_BITS-1:0]    wr_pending_counts,
  input  wire logic [CHANNELS*COUNT_BITS-1:0]    wr_buffer_counts,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   write_mode,
  output logic [CHANNELS-1:0]                    prepare_wr_mask,
  output logic [CHANNELS-1:0]                    prepare_rd_mask
);

  localparam int RES_W = 1 + 2 * CHANNELS;

  drws_pkg::cfg_t        cfg;
  drws_pkg::urgency_t    urg;
  drws_pkg::lane_flags_t flags [CHANNELS];

  logic                accept;
  logic                dec_mode;
  logic [CHANNELS-1:0] dec_prep_wr, dec_prep_rd;
  logic [RES_W-1:0]    dec_res, out_res, skid_res;
  logic                skid_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rd_count_threshold  <= drws_pkg::THR_W'(8);
      cfg.wr_count_threshold  <= drws_pkg::THR_W'(8);
      cfg.write_switch_delay  <= '0;
      cfg.prefer_write        <= 1'b0;
      cfg.wr_buffer_threshold <= drws_pkg::THR_W'(8);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        drws_pkg::REG_RD_COUNT_THR: cfg.rd_count_threshold  <= cfg_data[drws_pkg::THR_W-1:0];
        drws_pkg::REG_WR_COUNT_THR: cfg.wr_count_threshold  <= cfg_data[drws_pkg::THR_W-1:0];
        drws_pkg::REG_WR_SW_DELAY:  cfg.write_switch_delay  <= cfg_data;
        drws_pkg::REG_PREFER_WR:    cfg.prefer_write        <= cfg_data[0];
        drws_pkg::REG_WR_BUF_THR:   cfg.wr_buffer_threshold <= cfg_data[drws_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign urg.exp_rd           = |expired_rd_hit_opening;
  assign urg.exp_wr           = |expired_wr_hit_opening;
  assign urg.flush_rd         = |urgent_rd_hit_opening;
  assign urg.flush_wr_opening = |urgent_wr_hit_opening;
  assign urg.flush_wr_open    = |urgent_wr_hit_open;
  assign urg.rd_crit          = |rd_critical_hit_opening;
  assign urg.wr_crit          = |wr_critical_hit_open;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    drws_lane #(
      .COUNT_BITS (COUNT_BITS)
    ) u_lane (
      .rd_ready   (rd_ready_counts[c*COUNT_BITS +: COUNT_BITS]),
      .wr_ready   (wr_ready_counts[c*COUNT_BITS +: COUNT_BITS]),
      .rd_pending (rd_pending_counts[c*COUNT_BITS +: COUNT_BITS]),
      .wr_pending (wr_pending_counts[c*COUNT_BITS +: COUNT_BITS]),
      .wr_buffer  (wr_buffer_counts[c*COUNT_BITS +: COUNT_BITS]),
      .cfg        (cfg),
      .flags      (flags[c])
    );
  end

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;

  drws_decide #(
    .CHANNELS (CHANNELS)
  ) u_decide (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cfg        (cfg),
    .urg        (urg),
    .flags      (flags),
    .write_mode (dec_mode),
    .prep_wr    (dec_prep_wr),
    .prep_rd    (dec_prep_rd)
  );

  assign dec_res = {dec_mode, dec_prep_wr, dec_prep_rd};

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_res <= skid_valid ? skid_res : dec_res;
    end else if (accept) begin
      skid_res <= dec_res;
    end
  end

  assign write_mode      = out_res[RES_W-1];
  assign prepare_wr_mask = out_res[2*CHANNELS-1:CHANNELS];
  assign prepare_rd_mask = out_res[CHANNELS-1:0];

endmodule
`default_nettype wire

// ----- rtl/drws_lane.sv -----
// ---------------------------------------------------------------------------
// drws_lane
// Per-channel count checks against the configured thresholds.
// ---------------------------------------------------------------------------
`default_nettype none
module drws_lane #(
  parameter int COUNT_BITS = drws_pkg::COUNT_BITS_DEF
) (
  input  wire logic [COUNT_BITS-1:0]      rd_ready,
  input  wire logic [COUNT_BITS-1:0]      wr_ready,
  input  wire logic [COUNT_BITS-1:0]      rd_pending,
  input  wire logic [COUNT_BITS-1:0]      wr_pending,
  input  wire logic [COUNT_BITS-1:0]      wr_buffer,
  input  wire drws_pkg::cfg_t             cfg,
  output drws_pkg::lane_flags_t           flags
);

  localparam int CMP_W = (COUNT_BITS > drws_pkg::THR_W) ? COUNT_BITS : drws_pkg::THR_W;

  logic [CMP_W-1:0] ra, wa, wb, rthr, wthr, bthr;

  assign ra   = CMP_W'(rd_ready);
  assign wa   = CMP_W'(wr_ready);
  assign wb   = CMP_W'(wr_buffer);
  assign rthr = CMP_W'(cfg.rd_count_threshold);
  assign wthr = CMP_W'(cfg.wr_count_threshold);
  assign bthr = CMP_W'(cfg.wr_buffer_threshold);

  always_comb begin
    flags.rd_below  = ra < rthr;
    flags.wr_below  = wa < wthr;
    flags.rd_avail  = rd_ready != '0;
    flags.wr_avail  = wr_ready != '0;
    flags.rd_med    = flags.rd_avail && flags.rd_below;
    flags.wr_med    = flags.wr_avail && flags.wr_below;
    flags.rd_valid  = rd_pending != '0;
    flags.wr_valid  = wr_pending != '0;
    flags.buf_above = wb > bthr;
  end

endmodule
`default_nettype wire

// ----- rtl/drws_decide.sv -----
// ---------------------------------------------------------------------------
// drws_decide
// Merges lane results, walks the priority rules and holds mode and delay.
// ---------------------------------------------------------------------------
`default_nettype none
module drws_decide #(
  parameter int CHANNELS = drws_pkg::CHANNELS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire drws_pkg::cfg_t        cfg,
  input  wire drws_pkg::urgency_t    urg,
  input  wire drws_pkg::lane_flags_t flags [CHANNELS],
  output logic                       write_mode,
  output logic [CHANNELS-1:0]        prep_wr,
  output logic [CHANNELS-1:0]        prep_rd
);

  logic                         mode;
  logic                         delay_running, delay_running_next;
  logic [drws_pkg::DELAY_W-1:0] delay_elapsed, delay_elapsed_next;
  logic [drws_pkg::DELAY_W-1:0] elapsed_eff;

  logic [CHANNELS-1:0] rd_below, wr_below, rd_med_v, wr_med_v;
  logic [CHANNELS-1:0] rd_avail_v, wr_avail_v, rd_valid_v, wr_valid_v, buf_v;
  logic rd_high, wr_high, rd_med, wr_med, rd_avail_any, wr_avail_any;
  logic rd_valid_none, rd_valid_all, wr_valid_none, wr_valid_all;
  logic buf_above, rd_valid_one;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      rd_below[c]   = flags[c].rd_below;
      wr_below[c]   = flags[c].wr_below;
      rd_med_v[c]   = flags[c].rd_med;
      wr_med_v[c]   = flags[c].wr_med;
      rd_avail_v[c] = flags[c].rd_avail;
      wr_avail_v[c] = flags[c].wr_avail;
      rd_valid_v[c] = flags[c].rd_valid;
      wr_valid_v[c] = flags[c].wr_valid;
      buf_v[c]      = flags[c].buf_above;
    end
  end

  assign rd_high       = rd_below == '0;
  assign wr_high       = wr_below == '0;
  assign rd_med        = &rd_med_v;
  assign wr_med        = &wr_med_v;
  assign rd_avail_any  = |rd_avail_v;
  assign wr_avail_any  = |wr_avail_v;
  assign rd_valid_none = rd_valid_v == '0;
  assign rd_valid_all  = &rd_valid_v;
  assign wr_valid_none = wr_valid_v == '0;
  assign wr_valid_all  = &wr_valid_v;
  assign buf_above     = &buf_v;
  assign rd_valid_one  = !rd_valid_none &&
                         ((rd_valid_v & (rd_valid_v - CHANNELS'(1))) == '0);

  assign elapsed_eff = delay_running ? delay_elapsed : '0;

  always_comb begin
    write_mode         = 1'b0;
    prep_wr            = '0;
    prep_rd            = '0;
    delay_running_next = delay_running;
    delay_elapsed_next = delay_elapsed;
    if (!mode) begin
      delay_running_next = 1'b0;
      delay_elapsed_next = '0;
      priority if (urg.exp_rd) begin
        write_mode = 1'b0;
      end else if (urg.exp_wr) begin
        write_mode = 1'b1;
      end else if (urg.flush_rd) begin
        write_mode = 1'b0;
      end else if (urg.flush_wr_opening) begin
        write_mode = 1'b1;
      end else if (urg.rd_crit) begin
        write_mode = 1'b0;
      end else if (urg.wr_crit) begin
        write_mode = 1'b1;
      end else if (rd_high) begin
        write_mode = 1'b0;
      end else if (wr_high) begin
        write_mode = 1'b1;
      end else if (rd_med) begin
        write_mode = 1'b0;
        prep_wr    = wr_below;
      end else if (wr_med) begin
        prep_wr = '1;
        if (elapsed_eff >= cfg.write_switch_delay) begin
          write_mode = 1'b1;
        end else begin
          write_mode         = 1'b0;
          delay_running_next = 1'b1;
          delay_elapsed_next = (elapsed_eff == drws_pkg::DELAY_MAX) ?
                               elapsed_eff : elapsed_eff + drws_pkg::DELAY_W'(1);
        end
      end else if (rd_avail_any) begin
        write_mode = 1'b0;
      end else if (wr_avail_any) begin
        write_mode = buf_above;
        prep_wr    = buf_above ? '1 : '0;
      end else if (rd_valid_none) begin
        write_mode = !wr_valid_none || cfg.prefer_write;
      end else if (rd_valid_one) begin
        if (wr_valid_all) begin
          prep_wr    = '1;
          write_mode = buf_above;
        end
      end else begin
        write_mode = 1'b0;
      end
    end else begin
      priority if (urg.exp_rd) begin
        write_mode = 1'b0;
      end else if (urg.exp_wr) begin
        write_mode = 1'b1;
      end else if (urg.flush_rd) begin
        write_mode = 1'b0;
      end else if (urg.flush_wr_open) begin
        write_mode = 1'b1;
      end else if (urg.rd_crit) begin
        write_mode = 1'b0;
      end else if (urg.wr_crit) begin
        write_mode = 1'b1;
      end else if (wr_high) begin
        write_mode = 1'b1;
      end else if (rd_high) begin
        write_mode = 1'b0;
      end else if (wr_med) begin
        write_mode = 1'b1;
        prep_rd    = rd_below;
      end else if (rd_med) begin
        write_mode = 1'b0;
        prep_rd    = '1;
      end else if (wr_avail_any) begin
        write_mode = 1'b1;
      end else if (rd_avail_any) begin
        write_mode = 1'b0;
      end else if (wr_valid_none) begin
        write_mode = rd_valid_none && cfg.prefer_write;
      end else if (wr_valid_all) begin
        write_mode = 1'b1;
      end else if (rd_valid_all) begin
        write_mode = 1'b0;
        prep_rd    = '1;
      end else begin
        write_mode = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= 1'b0;
      delay_running <= 1'b0;
      delay_elapsed <= '0;
    end else if (accept) begin
      mode          <= write_mode;
      delay_running <= delay_running_next;
      delay_elapsed <= delay_elapsed_next;
    end
  end

endmodule
`default_nettype wire
